### hw/rtl/psc_pkg.sv
package psc_pkg;

    // cycles from an accepted request to its result strobe
    localparam int LATENCY = 9;

    // width of the configuration index port
    localparam int CFG_INDEX_W = 4;

    // 2*pi in Q13 and one in Q14
    localparam int TWO_PI_Q13 = 51472;
    localparam int ONE_Q14    = 16384;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_ANGLE     = 4'd0,
        REG_GAIN_RATE      = 4'd1,
        REG_PUMP_GAIN      = 4'd2,
        REG_KINETIC_COEF   = 4'd3,
        REG_POTENTIAL_COEF = 4'd4,
        REG_CATCH_ANGLE    = 4'd5,
        REG_CATCH_RATE     = 4'd6,
        REG_TORQUE_LIMIT   = 4'd7
    } reg_idx_t;

    // configuration register set shared by the front, multiplier and finish blocks
    typedef struct packed {
        logic signed [15:0] gain_angle;
        logic signed [15:0] gain_rate;
        logic [15:0]        pump_gain;
        logic [15:0]        kinetic_coef;
        logic [15:0]        potential_coef;
        logic [14:0]        catch_angle;
        logic [14:0]        catch_rate;
        logic [14:0]        torque_limit;
    } psc_cfg_t;

    localparam psc_cfg_t CFG_RESET = '{
        gain_angle:     16'sd0,
        gain_rate:      16'sd0,
        pump_gain:      16'd256,
        kinetic_coef:   16'd256,
        potential_coef: 16'd10045,
        catch_angle:    15'd3651,
        catch_rate:     15'd768,
        torque_limit:   15'd8192
    };

    // cos(pi/2 * t/16384) in Q14, evaluated only on constants to build the table
    function automatic logic [14:0] quarter_cos(input logic [31:0] t);
        longint u;
        longint w;
        longint p;
        u = longint'(t) <<< 2;
        w = (u * u) >>> 16;
        p = 60;
        p = 1367 - ((p * w) >>> 16);
        p = 16625 - ((p * w) >>> 16);
        p = 80852 - ((p * w) >>> 16);
        p = 65536 - ((p * w) >>> 16);
        if (p < 0)
        begin
            p = 0;
        end
        p = (p + 2) >>> 2;
        if (p > ONE_Q14)
        begin
            p = ONE_Q14;
        end
        return 15'(p);
    endfunction

endpackage

### hw/rtl/psc_front.sv
module psc_front #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                          clk,
    input  psc_pkg::psc_cfg_t             cfg,
    input  logic signed [15:0]            pole_angle,
    input  logic signed [15:0]            pole_rate,
    output logic signed [15:0]            angle,
    output logic signed [15:0]            rate,
    output logic                          mode,
    output logic [COS_TABLE_BITS-2:0]     cos_index,
    output logic                          cos_neg
);
    import psc_pkg::*;

    localparam int QN = 2 ** (COS_TABLE_BITS - 2);
    localparam logic [COS_TABLE_BITS-2:0] QUARTER = (COS_TABLE_BITS - 1)'(QN);

    logic [16:0]                 ext_a;
    logic [16:0]                 ext_r;
    logic [16:0]                 abs_a;
    logic [16:0]                 abs_r;
    logic [COS_TABLE_BITS-1:0]   idx;
    logic [1:0]                  quad;
    logic [COS_TABLE_BITS-3:0]   frac;

    logic signed [15:0]          angle_reg;
    logic signed [15:0]          rate_reg;
    logic                        mode_reg;
    logic [COS_TABLE_BITS-2:0]   cos_index_reg;
    logic                        cos_neg_reg;
    logic                        mode_next;
    logic [COS_TABLE_BITS-2:0]   cos_index_next;
    logic                        cos_neg_next;

    // magnitudes, straight down keeps 32768
    always_comb
    begin
        ext_a = {pole_angle[15], pole_angle};
        ext_r = {pole_rate[15], pole_rate};
        abs_a = pole_angle[15] ? (~ext_a + 17'd1) : ext_a;
        abs_r = pole_rate[15] ? (~ext_r + 17'd1) : ext_r;
    end

    // strict catch window test
    assign mode_next = (abs_a < {2'b00, cfg.catch_angle}) && (abs_r < {2'b00, cfg.catch_rate});

    // quarter-wave table index and sign from the top angle bits
    always_comb
    begin
        idx  = pole_angle[15 -: COS_TABLE_BITS];
        quad = idx[COS_TABLE_BITS-1 -: 2];
        frac = idx[COS_TABLE_BITS-3:0];
        cos_index_next = quad[0] ? (QUARTER - {1'b0, frac}) : {1'b0, frac};
        cos_neg_next   = quad[1] ^ quad[0];
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        angle_reg     <= pole_angle;
        rate_reg      <= pole_rate;
        mode_reg      <= mode_next;
        cos_index_reg <= cos_index_next;
        cos_neg_reg   <= cos_neg_next;
    end

    assign angle     = angle_reg;
    assign rate      = rate_reg;
    assign mode      = mode_reg;
    assign cos_index = cos_index_reg;
    assign cos_neg   = cos_neg_reg;

endmodule

### hw/rtl/psc_cos_rom.sv
module psc_cos_rom #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic [COS_TABLE_BITS-2:0]     cos_index,
    input  logic                          cos_neg,
    output logic signed [15:0]            cos_val
);
    import psc_pkg::*;

    localparam int DEPTH = 2 ** (COS_TABLE_BITS - 2) + 1;
    localparam int STEP  = 16 - COS_TABLE_BITS;

    logic [14:0]        tab [DEPTH];
    logic [15:0]        mag;
    logic signed [15:0] cos_next;
    logic signed [15:0] cos_reg;

    // quarter-wave table, built from constants at elaboration
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tab
        assign tab[i] = quarter_cos(32'(i) << STEP);
    end

    // lookup and quadrant sign
    always_comb
    begin
        mag      = {1'b0, tab[cos_index]};
        cos_next = cos_neg ? (16'd0 - mag) : mag;
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
    end

    assign cos_val = cos_reg;

endmodule

### hw/rtl/psc_mult.sv
module psc_mult (
    input  logic                clk,
    input  psc_pkg::psc_cfg_t   cfg,
    input  logic signed [15:0]  angle,
    input  logic signed [15:0]  rate,
    input  logic signed [15:0]  cos_val,
    output logic signed [63:0]  prod,
    output logic signed [28:0]  fbq,
    output logic                neg
);
    import psc_pkg::*;

    localparam logic signed [16:0] TWO_PI = 17'(TWO_PI_Q13);
    localparam logic signed [16:0] ONE    = 17'(ONE_Q14);

    // stage 2
    logic signed [31:0] rr_full;
    logic signed [31:0] pa_next;
    logic signed [31:0] pr_next;
    logic [30:0]        rr_next;
    logic signed [31:0] pa_reg;
    logic signed [31:0] pr_reg;
    logic [30:0]        rr_reg;
    logic               rneg_reg;
    logic               rnz_reg;
    // stage 3
    logic signed [16:0] cd;
    logic               cpos;
    logic signed [47:0] fa_next;
    logic [46:0]        ke_next;
    logic signed [33:0] pe_next;
    logic               neg3_next;
    logic signed [47:0] fa_reg;
    logic signed [31:0] pr3_reg;
    logic [46:0]        ke_reg;
    logic signed [33:0] pe_reg;
    logic               neg3_reg;
    // stage 4
    logic signed [53:0] s_next;
    logic signed [47:0] e_next;
    logic signed [53:0] s_reg;
    logic signed [47:0] e_reg;
    logic               neg4_reg;
    // stage 5
    logic signed [23:0] eh;
    logic [23:0]        el;
    logic [53:0]        sb;
    logic [39:0]        pl_next;
    logic signed [40:0] ph_next;
    logic signed [28:0] fbq_next;
    logic [39:0]        pl_reg;
    logic signed [40:0] ph_reg;
    logic signed [28:0] fbq_reg;
    logic               neg5_reg;
    // stage 6
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    logic signed [28:0] fbq6_reg;
    logic               neg6_reg;

    // gain products and rate squared
    always_comb
    begin
        rr_full = rate * rate;
        pa_next = cfg.gain_angle * angle;
        pr_next = cfg.gain_rate * rate;
        rr_next = rr_full[30:0];
    end

    // angle scale to radians, kinetic and potential terms, drive sign
    always_comb
    begin
        cd        = {cos_val[15], cos_val} - ONE;
        cpos      = !cos_val[15] && (cos_val != 16'sd0);
        fa_next   = pa_reg * TWO_PI;
        ke_next   = cfg.kinetic_coef * rr_reg;
        pe_next   = $signed({1'b0, cfg.potential_coef}) * cd;
        neg3_next = (rneg_reg && cpos) || (!rneg_reg && rnz_reg && cos_val[15]);
    end

    // feedback sum and energy error
    always_comb
    begin
        s_next = {{6{fa_reg[47]}}, fa_reg} + {pr3_reg[31], pr3_reg, 21'd0};
        e_next = {1'b0, ke_reg} + {{12{pe_reg[33]}}, pe_reg, 2'b00};
    end

    // pump gain partial products, feedback rounding
    always_comb
    begin
        eh       = e_reg[47:24];
        el       = e_reg[23:0];
        pl_next  = cfg.pump_gain * el;
        ph_next  = $signed({1'b0, cfg.pump_gain}) * eh;
        sb       = s_reg + (54'd1 << 24) - {53'd0, s_reg[53]};
        fbq_next = sb[53:25];
    end

    // partial product merge
    assign prod_next = {ph_reg[39:0], 24'd0} + {24'd0, pl_reg};

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        pr_reg   <= pr_next;
        rr_reg   <= rr_next;
        rneg_reg <= rate[15];
        rnz_reg  <= (rate != 16'sd0);

        fa_reg   <= fa_next;
        pr3_reg  <= pr_reg;
        ke_reg   <= ke_next;
        pe_reg   <= pe_next;
        neg3_reg <= neg3_next;

        s_reg    <= s_next;
        e_reg    <= e_next;
        neg4_reg <= neg3_reg;

        pl_reg   <= pl_next;
        ph_reg   <= ph_next;
        fbq_reg  <= fbq_next;
        neg5_reg <= neg4_reg;

        prod_reg <= prod_next;
        fbq6_reg <= fbq_reg;
        neg6_reg <= neg5_reg;
    end

    assign prod = prod_reg;
    assign fbq  = fbq6_reg;
    assign neg  = neg6_reg;

endmodule

### hw/rtl/psc_finish.sv
module psc_finish (
    input  logic                clk,
    input  psc_pkg::psc_cfg_t   cfg,
    input  logic signed [63:0]  prod,
    input  logic signed [28:0]  fbq,
    input  logic                neg,
    input  logic                mode,
    output logic signed [15:0]  torque
);
    import psc_pkg::*;

    // stage 7
    logic [63:0]        pb;
    logic signed [39:0] pq_next;
    logic signed [29:0] fbn_next;
    logic signed [39:0] pq_reg;
    logic signed [29:0] fbn_reg;
    logic               neg7_reg;
    // stage 8
    logic signed [40:0] pqx;
    logic signed [40:0] t_next;
    logic signed [40:0] t_reg;
    // stage 9
    logic signed [40:0] lim;
    logic signed [40:0] nlim;
    logic signed [15:0] torque_next;
    logic signed [15:0] torque_reg;

    // pump rounding to nearest, ties away from zero; feedback negation
    always_comb
    begin
        pb       = prod + (64'd1 << 23) - {63'd0, prod[63]};
        pq_next  = pb[63:24];
        fbn_next = 30'd0 - {fbq[28], fbq};
    end

    // mode select and drive sign
    always_comb
    begin
        pqx = {pq_reg[39], pq_reg};
        if (mode)
        begin
            t_next = {{11{fbn_reg[29]}}, fbn_reg};
        end
        else
        begin
            t_next = neg7_reg ? (41'd0 - pqx) : pqx;
        end
    end

    // saturation to the torque limit
    always_comb
    begin
        lim  = {26'd0, cfg.torque_limit};
        nlim = 41'd0 - lim;
        if (t_reg > lim)
        begin
            torque_next = lim[15:0];
        end
        else if (t_reg < nlim)
        begin
            torque_next = nlim[15:0];
        end
        else
        begin
            torque_next = t_reg[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pq_reg     <= pq_next;
        fbn_reg    <= fbn_next;
        neg7_reg   <= neg;
        t_reg      <= t_next;
        torque_reg <= torque_next;
    end

    assign torque = torque_reg;

endmodule

### hw/rtl/pendulum_swingup_controller.sv
// Pendulum swing-up controller with state-feedback catch.
//
// Requests: raise start with pole_angle and pole_rate; a request is taken at
// every rising edge with start high and busy low. busy is always low, so one
// request can be taken in every cycle.
// Results: done is high for exactly one cycle with drive_torque and catch_mode
// valid in that cycle, one result per request, in request order.
// Throughput: one request per cycle through the 9-stage pipeline (window test
// and table index, table read and 16x16 products, scaling products, feedback
// sum and energy error, split pump gain products and feedback rounding,
// product merge, pump rounding, feedback negation, sign select, saturation).
// Configuration: cfg_we, cfg_index and cfg_data write one register per edge;
// write only while no request is in flight. Indexes beyond 7 are ignored.
// Reset: rst_n clears the in-flight valid bits and loads the default register
// values; no result is lost to a stalling receiver since it cannot stall.
module pendulum_swingup_controller #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [15:0]                    pole_angle,
    input  logic signed [15:0]                    pole_rate,
    input  logic                                  cfg_we,
    input  logic [psc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [15:0]                           cfg_data,
    output logic                                  done,
    output logic signed [15:0]                    drive_torque,
    output logic                                  catch_mode
);
    import psc_pkg::*;

    psc_cfg_t                    cfg_reg;
    psc_cfg_t                    cfg_next;
    logic [LATENCY-1:0]          valid_reg;
    logic [LATENCY-1:0]          valid_next;
    logic [LATENCY-1:1]          mode_reg;
    logic                        accept;

    logic signed [15:0]          angle1;
    logic signed [15:0]          rate1;
    logic                        mode1;
    logic [COS_TABLE_BITS-2:0]   cos_index1;
    logic                        cos_neg1;
    logic signed [15:0]          cos2;
    logic signed [63:0]          prod6;
    logic signed [28:0]          fbq6;
    logic                        neg6;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_ANGLE:     cfg_next.gain_angle     = cfg_data;
                REG_GAIN_RATE:      cfg_next.gain_rate      = cfg_data;
                REG_PUMP_GAIN:      cfg_next.pump_gain      = cfg_data;
                REG_KINETIC_COEF:   cfg_next.kinetic_coef   = cfg_data;
                REG_POTENTIAL_COEF: cfg_next.potential_coef = cfg_data;
                REG_CATCH_ANGLE:    cfg_next.catch_angle    = cfg_data[14:0];
                REG_CATCH_RATE:     cfg_next.catch_rate     = cfg_data[14:0];
                REG_TORQUE_LIMIT:   cfg_next.torque_limit   = cfg_data[14:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // valid bits follow the data down the pipeline
    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // mode rides along with the payload
    always_ff @(posedge clk)
    begin
        mode_reg <= {mode_reg[LATENCY-2:1], mode1};
    end

    psc_front #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_front (
        .clk        (clk),
        .cfg        (cfg_reg),
        .pole_angle (pole_angle),
        .pole_rate  (pole_rate),
        .angle      (angle1),
        .rate       (rate1),
        .mode       (mode1),
        .cos_index  (cos_index1),
        .cos_neg    (cos_neg1)
    );

    psc_cos_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cos_rom (
        .clk       (clk),
        .cos_index (cos_index1),
        .cos_neg   (cos_neg1),
        .cos_val   (cos2)
    );

    psc_mult u_mult (
        .clk     (clk),
        .cfg     (cfg_reg),
        .angle   (angle1),
        .rate    (rate1),
        .cos_val (cos2),
        .prod    (prod6),
        .fbq     (fbq6),
        .neg     (neg6)
    );

    psc_finish u_finish (
        .clk    (clk),
        .cfg    (cfg_reg),
        .prod   (prod6),
        .fbq    (fbq6),
        .neg    (neg6),
        .mode   (mode_reg[LATENCY-3]),
        .torque (drive_torque)
    );

    assign done       = valid_reg[LATENCY-1];
    assign catch_mode = mode_reg[LATENCY-1];

endmodule

### hw/rtl/psc_checker.sv
module psc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] drive_torque
);
    import psc_pkg::*;

    // every request gives its result after the fixed latency
    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LATENCY) done)
        else $error("request without result");

    // no result without a request at the matching edge
    a_done_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // saturated torque never reaches the most negative code
    a_torque_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (drive_torque != -16'sd32768))
        else $error("torque out of range");

endmodule

bind pendulum_swingup_controller psc_checker u_psc_checker (.*);
